// ===== design/ffpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

  // Heap geometry
  localparam int NUM_PAGES   = 1024;
  localparam int PAGE_BYTES  = 4096;
  localparam int MAX_ENTRIES = 256;
  localparam logic [31:0] HEAP_BASE = 32'h8000_0000;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int NPG_W      = $clog2(NUM_PAGES + 1);
  localparam int ENT_W      = $clog2(MAX_ENTRIES);
  localparam int ECNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int TBL_W      = PAGE_W + NPG_W;

  // Commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_RUN    = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_SIZE  = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_MODE_OFF  = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd5;

  // Byte address of a page, wrapping modulo 2^32
  function automatic logic [31:0] page_addr(input logic [PAGE_W-1:0] pg);
    logic [63:0] sum;
    sum = 64'(HEAP_BASE) + (64'(pg) << PAGE_SHIFT);
    return sum[31:0];
  endfunction

  // Byte size of a page count, low 32 bits
  function automatic logic [31:0] page_bytes(input logic [NPG_W-1:0] cnt);
    logic [63:0] prod;
    prod = 64'(cnt) << PAGE_SHIFT;
    return prod[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/ffpa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data
module ffpa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/first_fit_page_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// After reset a clearing pass writes every page of the bitmap free, with busy high.
// Allocate: bitmap scanned one page a cycle, then each page of the run marked used. Free: table
//   searched one entry a cycle, the last live entry moved into the freed slot, then each page
//   cleared. A rejected allocate or a free on an empty table answers in the cycle after the
//   transfer. One command at a time; each result is a one-cycle strobe, for a busy command in
//   the first cycle with busy low. Reset is synchronous, active low; no result stall.
module first_fit_page_allocator (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_command,
  input  wire logic [31:0]              in_size_bytes,
  input  wire logic [31:0]              in_address,
  output logic                          out_valid,
  output logic [31:0]                   out_region_address,
  output logic [31:0]                   out_region_bytes,
  output logic [ffpa_pkg::ST_W-1:0]     out_status,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_first_fit_enabled
);

  import ffpa_pkg::*;

  localparam int PGC_W = PAGE_W + 1;

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_MARK   = 3'd3;
  localparam logic [2:0] S_TSRCH  = 3'd4;
  localparam logic [2:0] S_TLAST  = 3'd5;
  localparam logic [2:0] S_TMOVE  = 3'd6;
  localparam logic [2:0] S_UNMARK = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic              mode_r;
  logic [PGC_W-1:0]  pg_rd_r, pg_rd_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [PAGE_W-1:0] chk_page_r, chk_page_nxt;
  logic [NPG_W-1:0]  run_r, run_nxt;
  logic [NPG_W-1:0]  npages_r, npages_nxt;
  logic [PAGE_W-1:0] start_pg_r, start_pg_nxt;
  logic [NPG_W-1:0]  cnt_r, cnt_nxt;
  logic [PGC_W-1:0]  mk_page_r, mk_page_nxt;
  logic [NPG_W-1:0]  mk_left_r, mk_left_nxt;
  logic [ECNT_W-1:0] ent_rd_r, ent_rd_nxt;
  logic              ent_vld_r, ent_vld_nxt;
  logic [ENT_W-1:0]  ent_chk_r, ent_chk_nxt;
  logic [ENT_W-1:0]  hit_r, hit_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [ECNT_W-1:0] ecount_r, ecount_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_addr_r, out_addr_nxt;
  logic [31:0]       out_bytes_r, out_bytes_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;

  // RAM ports
  logic              page_we;
  logic [PAGE_W-1:0] page_waddr, page_raddr;
  logic              page_wdata, page_rdata;
  logic              tbl_we;
  logic [ENT_W-1:0]  tbl_waddr, tbl_raddr;
  logic [TBL_W-1:0]  tbl_wdata, tbl_rdata;

  // Request size decode
  logic [32:0]       size_sum;
  logic [32:0]       npg_full;
  logic [63:0]       size_rounded;
  logic              size_bad;
  logic [NPG_W-1:0]  run_inc;
  logic [PGC_W-1:0]  found_start;
  logic [PAGE_W-1:0] tbl_start;
  logic [NPG_W-1:0]  tbl_cnt;
  logic [ECNT_W-1:0] ecount_dec;

  assign size_sum     = {1'b0, in_size_bytes} + 33'(PAGE_BYTES - 1);
  assign npg_full     = size_sum >> PAGE_SHIFT;
  assign size_rounded = 64'(npg_full) << PAGE_SHIFT;
  assign size_bad     = (npg_full == '0) || (npg_full > 33'(NUM_PAGES)) ||
                        (size_rounded[63:32] != '0);

  assign run_inc     = run_r + NPG_W'(1);
  assign found_start = PGC_W'(chk_page_r) + PGC_W'(1) - PGC_W'(npages_r);
  assign tbl_start   = tbl_rdata[TBL_W-1:NPG_W];
  assign tbl_cnt     = tbl_rdata[NPG_W-1:0];
  assign ecount_dec  = ecount_r - ECNT_W'(1);

  // Page bitmap, one bit per page
  ffpa_ram #(.WIDTH(1), .DEPTH(NUM_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (page_waddr),
    .wdata (page_wdata),
    .raddr (page_raddr),
    .rdata (page_rdata)
  );

  // Allocation table: start page and page count
  ffpa_ram #(.WIDTH(TBL_W), .DEPTH(MAX_ENTRIES)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Control sequencer
  always_comb begin
    state_nxt      = state_r;
    pg_rd_nxt      = pg_rd_r;
    chk_vld_nxt    = 1'b0;
    chk_page_nxt   = chk_page_r;
    run_nxt        = run_r;
    npages_nxt     = npages_r;
    start_pg_nxt   = start_pg_r;
    cnt_nxt        = cnt_r;
    mk_page_nxt    = mk_page_r;
    mk_left_nxt    = mk_left_r;
    ent_rd_nxt     = ent_rd_r;
    ent_vld_nxt    = 1'b0;
    ent_chk_nxt    = ent_chk_r;
    hit_nxt        = hit_r;
    addr_nxt       = addr_r;
    ecount_nxt     = ecount_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_bytes_nxt  = out_bytes_r;
    out_status_nxt = out_status_r;

    page_we    = 1'b0;
    page_waddr = mk_page_r[PAGE_W-1:0];
    page_wdata = 1'b0;
    page_raddr = pg_rd_r[PAGE_W-1:0];
    tbl_we     = 1'b0;
    tbl_waddr  = ecount_r[ENT_W-1:0];
    tbl_wdata  = {start_pg_r, npages_r};
    tbl_raddr  = ent_rd_r[ENT_W-1:0];

    unique case (state_r)
      // Clear the bitmap after reset
      S_CLR: begin
        page_we     = 1'b1;
        mk_page_nxt = mk_page_r + PGC_W'(1);
        if (mk_page_r == PGC_W'(NUM_PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a command; errors answer without going busy
      S_IDLE: begin
        if (start) begin
          if (in_command == CMD_FREE) begin
            addr_nxt = in_address;
            if (ecount_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_bytes_nxt  = '0;
              out_status_nxt = ST_NOT_FOUND;
            end else begin
              ent_rd_nxt = '0;
              state_nxt  = S_TSRCH;
            end
          end else begin
            if (!mode_r || size_bad || (ecount_r >= ECNT_W'(MAX_ENTRIES))) begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = '0;
              out_bytes_nxt = '0;
              if (!mode_r) begin
                out_status_nxt = ST_MODE_OFF;
              end else if (size_bad) begin
                out_status_nxt = ST_BAD_SIZE;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end else begin
              npages_nxt = npg_full[NPG_W-1:0];
              pg_rd_nxt  = '0;
              run_nxt    = '0;
              state_nxt  = S_SCAN;
            end
          end
        end
      end

      // Stream the bitmap, counting free pages in the current run
      S_SCAN: begin
        if (pg_rd_r < PGC_W'(NUM_PAGES)) begin
          pg_rd_nxt    = pg_rd_r + PGC_W'(1);
          chk_vld_nxt  = 1'b1;
          chk_page_nxt = pg_rd_r[PAGE_W-1:0];
        end
        if (chk_vld_r) begin
          if (page_rdata) begin
            run_nxt = '0;
          end else begin
            run_nxt = run_inc;
          end
          if (!page_rdata && (run_inc == npages_r)) begin
            start_pg_nxt = found_start[PAGE_W-1:0];
            mk_page_nxt  = found_start;
            mk_left_nxt  = npages_r;
            chk_vld_nxt  = 1'b0;
            state_nxt    = S_MARK;
          end else if (chk_page_r == PAGE_W'(NUM_PAGES - 1)) begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_bytes_nxt  = '0;
            out_status_nxt = ST_NO_RUN;
            chk_vld_nxt    = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end

      // Mark the run used; the entry is recorded with the last page
      S_MARK: begin
        page_we     = 1'b1;
        page_wdata  = 1'b1;
        mk_page_nxt = mk_page_r + PGC_W'(1);
        mk_left_nxt = mk_left_r - NPG_W'(1);
        if (mk_left_r <= NPG_W'(1)) begin
          tbl_we         = 1'b1;
          ecount_nxt     = ecount_r + ECNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = page_addr(start_pg_r);
          out_bytes_nxt  = page_bytes(npages_r);
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      // Stream live entries, stop at the first entry whose start address matches
      S_TSRCH: begin
        if (ent_rd_r < ecount_r) begin
          ent_rd_nxt  = ent_rd_r + ECNT_W'(1);
          ent_vld_nxt = 1'b1;
          ent_chk_nxt = ent_rd_r[ENT_W-1:0];
        end
        if (ent_vld_r) begin
          if (page_addr(tbl_start) == addr_r) begin
            hit_nxt      = ent_chk_r;
            start_pg_nxt = tbl_start;
            cnt_nxt      = tbl_cnt;
            ent_vld_nxt  = 1'b0;
            state_nxt    = S_TLAST;
          end else if (ECNT_W'(ent_chk_r) == ecount_dec) begin
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_bytes_nxt  = '0;
            out_status_nxt = ST_NOT_FOUND;
            ent_vld_nxt    = 1'b0;
            state_nxt      = S_IDLE;
          end
        end
      end

      // Read the last live entry
      S_TLAST: begin
        tbl_raddr = ecount_dec[ENT_W-1:0];
        state_nxt = S_TMOVE;
      end

      // Move it into the freed slot
      S_TMOVE: begin
        tbl_we      = 1'b1;
        tbl_waddr   = hit_r;
        tbl_wdata   = tbl_rdata;
        ecount_nxt  = ecount_dec;
        mk_page_nxt = PGC_W'(start_pg_r);
        mk_left_nxt = cnt_r;
        state_nxt   = S_UNMARK;
      end

      // Clear the freed pages
      S_UNMARK: begin
        page_we     = (mk_page_r < PGC_W'(NUM_PAGES));
        mk_page_nxt = mk_page_r + PGC_W'(1);
        mk_left_nxt = mk_left_r - NPG_W'(1);
        if (mk_left_r <= NPG_W'(1)) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = page_addr(start_pg_r);
          out_bytes_nxt  = page_bytes(cnt_r);
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      mk_page_r   <= '0;
      chk_vld_r   <= 1'b0;
      ent_vld_r   <= 1'b0;
      ecount_r    <= '0;
      mode_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mk_page_r   <= mk_page_nxt;
      chk_vld_r   <= chk_vld_nxt;
      ent_vld_r   <= ent_vld_nxt;
      ecount_r    <= ecount_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_first_fit_enabled;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pg_rd_r      <= pg_rd_nxt;
    chk_page_r   <= chk_page_nxt;
    run_r        <= run_nxt;
    npages_r     <= npages_nxt;
    start_pg_r   <= start_pg_nxt;
    cnt_r        <= cnt_nxt;
    mk_left_r    <= mk_left_nxt;
    ent_rd_r     <= ent_rd_nxt;
    ent_chk_r    <= ent_chk_nxt;
    hit_r        <= hit_nxt;
    addr_r       <= addr_nxt;
    out_addr_r   <= out_addr_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_region_address = out_addr_r;
  assign out_region_bytes   = out_bytes_r;
  assign out_status         = out_status_r;

endmodule

`default_nettype wire

// ===== design/ffpa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ffpa_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     out_valid,
  input wire logic [31:0]              out_region_address,
  input wire logic [31:0]              out_region_bytes,
  input wire logic [ffpa_pkg::ST_W-1:0] out_status
);

  import ffpa_pkg::*;

  // A result only follows an accepted command or a busy period
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a command");

  // Every accepted command either answers next cycle or goes busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither answered nor busy");

  // Failures carry zero address and size
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_region_address == '0) && (out_region_bytes == '0)))
    else $error("failure result with nonzero payload");

  // Successful results cover whole pages
  a_ok_pages: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_OK)) |->
      ((out_region_bytes != '0) && (out_region_bytes[PAGE_SHIFT-1:0] == '0)))
    else $error("ok result with size not a whole number of pages");

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ffpa_pkg::*;

  localparam bit FIRST_FIT_OFF = 1'b0;
  localparam bit FIRST_FIT_ON  = 1'b1;
  // Worst-case item: full bitmap scan plus marking every page
  localparam int ITEM_LATENCY = 2 * NUM_PAGES + 64;

  typedef struct packed {
    logic [31:0]     addr;
    logic [31:0]     nbytes;
    logic [ST_W-1:0] status;
  } alloc_result_t;

  // Directed row; expected fields are used only when typed is set
  typedef struct {
    bit              set_mode;
    bit              mode_val;
    logic            cmd;
    logic [31:0]     size_bytes;
    logic [31:0]     address;
    bit              typed;
    logic [31:0]     w_addr;
    logic [31:0]     w_bytes;
    logic [ST_W-1:0] w_status;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_command;
  logic [31:0]         in_size_bytes;
  logic [31:0]         in_address;
  logic                out_valid;
  logic [31:0]         out_region_address;
  logic [31:0]         out_region_bytes;
  logic [ST_W-1:0]     out_status;
  logic                cfg_we;
  logic                cfg_first_fit_enabled;

  // Heap shadow state
  bit                  page_taken [NUM_PAGES];
  logic [PAGE_W-1:0]   tbl_start [MAX_ENTRIES];
  logic [NPG_W-1:0]    tbl_pages [MAX_ENTRIES];
  int unsigned         live_count;
  bit                  ff_enabled;

  alloc_result_t       pending_results[$];
  int unsigned         fail_count;

  stim_row_t directed_rows [28] = '{
    '{0, 0, CMD_ALLOC, 32'd0,        32'd0,        1, 32'h0,        32'h0,        ST_BAD_SIZE},
    '{0, 0, CMD_ALLOC, 32'd1,        32'd0,        1, 32'h8000_0000, 32'h1000,    ST_OK},
    '{0, 0, CMD_ALLOC, 32'd4096,     32'd0,        1, 32'h8000_1000, 32'h1000,    ST_OK},
    '{0, 0, CMD_ALLOC, 32'd4097,     32'd0,        1, 32'h8000_2000, 32'h2000,    ST_OK},
    '{0, 0, CMD_ALLOC, 32'hFFFF_FFFF, 32'd0,       1, 32'h0,        32'h0,        ST_BAD_SIZE},
    '{0, 0, CMD_ALLOC, 32'h0040_0001, 32'd0,       1, 32'h0,        32'h0,        ST_BAD_SIZE},
    '{0, 0, CMD_ALLOC, 32'h0040_0000, 32'd0,       1, 32'h0,        32'h0,        ST_NO_RUN},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_1000,       1, 32'h8000_1000, 32'h1000,    ST_OK},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_1000,       1, 32'h0,        32'h0,        ST_NOT_FOUND},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_1001,       1, 32'h0,        32'h0,        ST_NOT_FOUND},
    '{0, 0, CMD_ALLOC, 32'd1,        32'd0,        1, 32'h8000_1000, 32'h1000,    ST_OK},
    '{0, 0, CMD_ALLOC, 32'h2000,     32'd0,        1, 32'h8000_4000, 32'h2000,    ST_OK},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_0000,       1, 32'h8000_0000, 32'h1000,    ST_OK},
    '{0, 0, CMD_FREE,  32'd0, 32'h0,               1, 32'h0,        32'h0,        ST_NOT_FOUND},
    '{0, 0, CMD_FREE,  32'd0, 32'hFFFF_FFFF,       1, 32'h0,        32'h0,        ST_NOT_FOUND},
    '{0, 0, CMD_ALLOC, 32'h3000,     32'd0,        1, 32'h8000_6000, 32'h3000,    ST_OK},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_2000,       1, 32'h8000_2000, 32'h2000,    ST_OK},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_4000,       1, 32'h8000_4000, 32'h2000,    ST_OK},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_1000,       1, 32'h8000_1000, 32'h1000,    ST_OK},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_6000,       1, 32'h8000_6000, 32'h3000,    ST_OK},
    '{0, 0, CMD_ALLOC, 32'h0040_0000, 32'd0,       1, 32'h8000_0000, 32'h0040_0000, ST_OK},
    '{0, 0, CMD_ALLOC, 32'd1,        32'd0,        1, 32'h0,        32'h0,        ST_NO_RUN},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_0000,       1, 32'h8000_0000, 32'h0040_0000, ST_OK},
    '{0, 0, CMD_ALLOC, 32'h003F_FFFF, 32'd0,       0, 32'h0,        32'h0,        ST_OK},
    // Mode off wins over a bad size; frees still work while off
    '{1, FIRST_FIT_OFF, CMD_ALLOC, 32'd0, 32'd0,   1, 32'h0,        32'h0,        ST_MODE_OFF},
    '{0, 0, CMD_ALLOC, 32'd1,        32'd0,        1, 32'h0,        32'h0,        ST_MODE_OFF},
    '{0, 0, CMD_FREE,  32'd0, 32'h8000_0000,       1, 32'h8000_0000, 32'h0040_0000, ST_OK},
    '{1, FIRST_FIT_ON, CMD_ALLOC, 32'd5, 32'd0,    0, 32'h0,        32'h0,        ST_OK}
  };

  first_fit_page_allocator dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_command            (in_command),
    .in_size_bytes         (in_size_bytes),
    .in_address            (in_address),
    .out_valid             (out_valid),
    .out_region_address    (out_region_address),
    .out_region_bytes      (out_region_bytes),
    .out_status            (out_status),
    .cfg_we                (cfg_we),
    .cfg_first_fit_enabled (cfg_first_fit_enabled)
  );

  always #4 clk = ~clk;

  // Heap address of a page, wraps at 32 bits
  function automatic logic [31:0] region_base(input int unsigned pg);
    return HEAP_BASE + 32'(pg) * 32'(PAGE_BYTES);
  endfunction

  // First-fit allocate on the shadow heap
  function automatic alloc_result_t alloc_outcome(input logic [31:0] nbytes);
    logic [63:0]   npg;
    int unsigned   run;
    int            first;
    alloc_result_t res;
    res = '{32'd0, 32'd0, ST_MODE_OFF};
    if (!ff_enabled) return res;
    npg = (64'(nbytes) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
    if (npg == 64'd0 || npg > 64'(NUM_PAGES) ||
        npg * 64'(PAGE_BYTES) > 64'hFFFF_FFFF) begin
      res.status = ST_BAD_SIZE;
      return res;
    end
    if (live_count >= MAX_ENTRIES) begin
      res.status = ST_FULL;
      return res;
    end
    run = 0;
    first = -1;
    for (int p = 0; p < NUM_PAGES; p++) begin
      if (page_taken[p]) begin
        run = 0;
      end else begin
        run++;
        if (64'(run) == npg) begin
          first = p + 1 - int'(run);
          break;
        end
      end
    end
    if (first < 0) begin
      res.status = ST_NO_RUN;
      return res;
    end
    for (int p = first; p < first + int'(run); p++) page_taken[p] = 1'b1;
    tbl_start[live_count] = PAGE_W'(first);
    tbl_pages[live_count] = NPG_W'(run);
    live_count++;
    return '{region_base(first), 32'(npg * 64'(PAGE_BYTES)), ST_OK};
  endfunction

  // Free by start address; last live entry fills the hole
  function automatic alloc_result_t free_outcome(input logic [31:0] addr);
    int            hit;
    int unsigned   first;
    int unsigned   cnt;
    int unsigned   last;
    hit = -1;
    for (int e = 0; e < int'(live_count); e++) begin
      if (region_base(tbl_start[e]) == addr) begin
        hit = e;
        break;
      end
    end
    if (hit < 0) return '{32'd0, 32'd0, ST_NOT_FOUND};
    first = tbl_start[hit];
    cnt = tbl_pages[hit];
    for (int unsigned i = 0; i < cnt; i++)
      if (first + i < NUM_PAGES) page_taken[first + i] = 1'b0;
    last = live_count - 1;
    tbl_start[hit] = tbl_start[last];
    tbl_pages[hit] = tbl_pages[last];
    live_count = last;
    return '{region_base(first), 32'(cnt) * 32'(PAGE_BYTES), ST_OK};
  endfunction

  // Mostly small requests, some large, some just over the heap, a few bad ones
  function automatic logic [31:0] pick_alloc_size();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(1, 8 * PAGE_BYTES);
    if (roll < 75) return 32'($urandom_range(1, 16)) * 32'(PAGE_BYTES);
    if (roll < 85) return $urandom_range(1, 64 * PAGE_BYTES);
    if (roll < 90) return $urandom_range(1, NUM_PAGES * PAGE_BYTES);
    if (roll < 95)
      return $urandom_range(NUM_PAGES * PAGE_BYTES + 1, (NUM_PAGES + 1) * PAGE_BYTES);
    if (roll < 97) return 32'd0;
    return $urandom;
  endfunction

  function automatic logic [31:0] live_region_addr();
    return region_base(tbl_start[$urandom_range(0, live_count - 1)]);
  endfunction

  // Free addresses that mostly miss: page-aligned guesses, near misses, noise
  function automatic logic [31:0] stray_addr();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return region_base($urandom_range(0, NUM_PAGES - 1));
    if (roll < 70 && live_count != 0)
      return live_region_addr() + $urandom_range(1, PAGE_BYTES - 1);
    return $urandom;
  endfunction

  // Drive one command and wait for its transfer; start stays high afterwards
  task automatic issue_item(input logic cmd, input logic [31:0] nbytes,
                            input logic [31:0] addr, input bit typed,
                            input alloc_result_t want);
    alloc_result_t predicted;
    in_command    <= cmd;
    in_size_bytes <= nbytes;
    in_address    <= addr;
    start         <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    if (cmd == CMD_ALLOC) predicted = alloc_outcome(nbytes);
    else predicted = free_outcome(addr);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic pause(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_mode(input bit val);
    settle();
    cfg_we                <= 1'b1;
    cfg_first_fit_enabled <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    ff_enabled = val;
  endtask

  // Random command: unused field carries noise
  task automatic random_item(input int gap_pct);
    logic        cmd;
    logic [31:0] nbytes;
    logic [31:0] addr;
    int          roll;
    nbytes = $urandom;
    addr   = $urandom;
    roll   = $urandom_range(0, 99);
    if (live_count == 0 || roll < 50) begin
      cmd    = CMD_ALLOC;
      nbytes = pick_alloc_size();
    end else begin
      cmd  = CMD_FREE;
      addr = (roll < 85) ? live_region_addr() : stray_addr();
    end
    if ($urandom_range(0, 99) < gap_pct) pause($urandom_range(1, 7));
    issue_item(cmd, nbytes, addr, 1'b0, '0);
  endtask

  // Result checker: the receiver always takes the strobe
  always @(posedge clk) begin
    alloc_result_t want;
    if (out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result addr=%h bytes=%h status=%0d", $time,
                 out_region_address, out_region_bytes, out_status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_region_address !== want.addr || out_region_bytes !== want.nbytes ||
            out_status !== want.status) begin
          $display("%0t: mismatch expected addr=%h bytes=%h status=%0d, got addr=%h bytes=%h status=%0d",
                   $time, want.addr, want.nbytes, want.status,
                   out_region_address, out_region_bytes, out_status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n                 <= 1'b0;
    start                 <= 1'b0;
    in_command            <= CMD_ALLOC;
    in_size_bytes         <= 32'd0;
    in_address            <= 32'd0;
    cfg_we                <= 1'b0;
    cfg_first_fit_enabled <= FIRST_FIT_ON;
    live_count = 0;
    ff_enabled = FIRST_FIT_ON;
    fail_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows; the clearing pass after reset holds the first transfer off
    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_mode) write_mode(directed_rows[i].mode_val);
      else if ($urandom_range(0, 99) < 30) pause($urandom_range(1, 7));
      issue_item(directed_rows[i].cmd, directed_rows[i].size_bytes, directed_rows[i].address,
                 directed_rows[i].typed,
                 '{directed_rows[i].w_addr, directed_rows[i].w_bytes, directed_rows[i].w_status});
    end

    // Mixed traffic, with one full drain halfway through
    for (int n = 0; n < 130; n++) begin
      if (n == 65) settle();
      random_item(30);
    end

    // Allocation gated off
    write_mode(FIRST_FIT_OFF);
    for (int n = 0; n < 50; n++) random_item(50);
    write_mode(FIRST_FIT_ON);

    // Release every live region
    while (live_count != 0) begin
      if ($urandom_range(0, 99) < 20) pause($urandom_range(1, 7));
      issue_item(CMD_FREE, $urandom, live_region_addr(), 1'b0, '0);
    end

    // Fill the table with one-page regions, then push past full
    while (live_count < MAX_ENTRIES)
      issue_item(CMD_ALLOC, $urandom_range(1, PAGE_BYTES), $urandom, 1'b0, '0);
    issue_item(CMD_ALLOC, 32'd0, $urandom, 1'b0, '0);
    for (int n = 0; n < 6; n++) issue_item(CMD_ALLOC, pick_alloc_size(), $urandom, 1'b0, '0);
    issue_item(CMD_FREE, $urandom, stray_addr(), 1'b0, '0);

    // Back-to-back tail, no idling
    for (int n = 0; n < 70; n++) random_item(0);

    settle();
    repeat (ITEM_LATENCY) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
